### sv/deq_pkg.sv
package deq_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_LOAD = 2'd2
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // access the store and update the ring pointers
    logic load;     // move the result into the output register
  } dp_cmd_t;

endpackage

### sv/deq_ctrl.sv
module deq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output deq_pkg::dp_cmd_t cmd_o
);
  import deq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_xfer;
  logic        load_ok;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign load_ok = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_LOAD;
      S_LOAD: begin
        if (load_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_LOAD: cmd_o.load = load_ok;
      default: in_stall_o = 1'b1;
    endcase
  end

  // output valid holds until the result transfer
  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_stall_i) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted request always goes on to the store access
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_EXEC)
    else $error("accepted request did not start execution");

  // a new result appears only from the load step
  a_rise_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_LOAD))
    else $error("result valid rose outside the load step");

  // a result is never loaded over one still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

### sv/deq_datapath.sv
module deq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  deq_pkg::dp_cmd_t                    cmd_i,
  input  logic [deq_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [deq_pkg::WORD_W-1:0]   push_value_i,
  output logic signed [deq_pkg::WORD_W-1:0]   read_value_o,
  output logic [deq_pkg::STATUS_W-1:0]        status_o,
  output logic                                now_empty_o
);
  import deq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

  // request registers
  logic [ACTION_W-1:0]      act_q;
  logic signed [WORD_W-1:0] val_q;

  // ring state
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;

  // store and read port
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              rd_en_q;
  status_e           st_q, st_d;

  // output register
  logic signed [WORD_W-1:0] read_value_q;
  logic [STATUS_W-1:0]      status_q;
  logic                     now_empty_q;

  logic          full, empty;
  logic [IW-1:0] front_dec, front_inc, back_pos, last_pos;
  logic [SW-1:0] back_sum, last_sum;
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;

  assign full  = (count_q == DEPTH_CNT);
  assign empty = (count_q == '0);

  // ring position arithmetic, sums stay below twice the depth while the ring holds an entry
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign last_sum  = back_sum - 1'b1;
  assign back_pos  = (back_sum >= DEPTH_SUM) ? IW'(back_sum - DEPTH_SUM) : IW'(back_sum);
  assign last_pos  = (last_sum >= DEPTH_SUM) ? IW'(last_sum - DEPTH_SUM) : IW'(last_sum);

  // request decode
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = back_pos;
    rd_addr = front_q;
    st_d    = ST_DONE;
    case (act_q)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          wr_en   = cmd_i.exec;
          count_d = count_q + 1'b1;
          if (act_q == ACT_PUSH_FRONT) begin
            wr_addr = front_dec;
            front_d = front_dec;
          end
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          rd_en = cmd_i.exec;
          if (!(act_q inside {ACT_POP_FRONT, ACT_PEEK_FRONT})) rd_addr = last_pos;
          if (act_q == ACT_POP_FRONT) begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end else if (act_q == ACT_POP_BACK) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: st_d = ST_DONE;
    endcase
  end

  // store access, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= val_q;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      val_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      rd_en_q <= rd_en;
      st_q    <= st_d;
    end
    if (cmd_i.load) begin
      read_value_q <= rd_en_q ? $signed(rdata_q) : '0;
      status_q     <= st_q;
      now_empty_q  <= empty;
    end
  end

  // ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign now_empty_o  = now_empty_q;

  // entry count never passes the depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above depth");

  // front index stays inside the ring
  a_front_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_IDX)
    else $error("front index outside the ring");

  // an accepted push grows the count by one
  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && wr_en) |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the entry count");

endmodule

### sv/double_ended_queue_top.sv
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-------------------------------------
// request  | in_valid_i  | in_stall_o  | action_i, push_value_i
// result   | out_valid_o | out_stall_i | read_value_o, status_o, now_empty_o
//
// each request passes through three steps: capture, store access, result load
// the single-port ring store with a registered read sets these steps
// one request is in flight at a time; the output register holds a result
// while the next request is captured and executed
// reset clears the front index, the count, the controller state and the
// result valid flag; the store needs no clearing pass
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [deq_pkg::ACTION_W-1:0]      action_i,
  input  logic signed [deq_pkg::WORD_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [deq_pkg::WORD_W-1:0] read_value_o,
  output logic [deq_pkg::STATUS_W-1:0]      status_o,
  output logic                              now_empty_o
);
  import deq_pkg::*;

  dp_cmd_t cmd;

  // sequencing and handshakes
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // ring store and pointers
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .now_empty_o  (now_empty_o)
  );

endmodule
